// ----- rtl/core/swrl_pkg.sv -----
// Shared types and constants of the sliding window order rate limiter.
package swrl_pkg;

    // Storage sizes
    localparam int LOG_DEPTH    = 64;
    localparam int SUBMIT_DEPTH = 16;
    localparam int MOD_DEPTH    = 16;
    localparam int CANCEL_DEPTH = 16;

    localparam int LOG_AW = $clog2(LOG_DEPTH);
    localparam int LOG_FW = $clog2(LOG_DEPTH + 1);
    localparam int SUB_AW = $clog2(SUBMIT_DEPTH);
    localparam int SUB_FW = $clog2(SUBMIT_DEPTH + 1);
    localparam int MOD_AW = $clog2(MOD_DEPTH);
    localparam int MOD_FW = $clog2(MOD_DEPTH + 1);
    localparam int CAN_AW = $clog2(CANCEL_DEPTH);
    localparam int CAN_FW = $clog2(CANCEL_DEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_WINDOW_LIMIT  = 1'b0;
    localparam logic CFG_WINDOW_LENGTH = 1'b1;
    localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd1000;

    // Request kinds
    localparam logic [2:0] KIND_SUBMIT     = 3'd0;
    localparam logic [2:0] KIND_MOD_PRICE  = 3'd1;
    localparam logic [2:0] KIND_MOD_QTY    = 3'd2;
    localparam logic [2:0] KIND_CANCEL     = 3'd3;
    localparam logic [2:0] KIND_TICK       = 3'd4;
    localparam logic [2:0] KIND_PAUSE      = 3'd5;
    localparam logic [2:0] KIND_CANCEL_ALL = 3'd6;
    localparam logic [2:0] KIND_RAW_ADD    = 3'd7;

    // Result status codes
    localparam logic [2:0] ST_ALLOWED   = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_UPDATED   = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_ACTION    = 3'd4;
    localparam logic [2:0] ST_NO_ACTION = 3'd5;
    localparam logic [2:0] ST_CANCELED  = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    // Drained action types
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_CANCEL    = 3'd1;
    localparam logic [2:0] ACT_MOD_PRICE = 3'd2;
    localparam logic [2:0] ACT_MOD_QTY   = 3'd3;
    localparam logic [2:0] ACT_SUBMIT    = 3'd4;

    // Order class from which pause leaves entries alone
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic [62:0]        now;
        logic [15:0]        order_id;
        logic signed [31:0] new_price;
        logic [31:0]        new_quantity;
        logic [1:0]         order_class;
        logic [15:0]        add_count;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         action_type;
        logic [15:0]        out_order_id;
        logic signed [31:0] out_price;
        logic [31:0]        out_quantity;
        logic [15:0]        count_in_window;
        logic [15:0]        count_left;
        logic               last_result;
    } out_word_t;

    typedef struct packed {
        logic [62:0] stamp;
        logic [15:0] cnt;
    } log_entry_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] price;
        logic [31:0] qty;
        logic [1:0]  cls;
    } sub_entry_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] price;
        logic [31:0] qty;
        logic        is_qty;
    } mod_entry_t;

endpackage

// ----- rtl/core/sliding_window_order_rate_limiter_top.sv -----
// Rate limiter with time-stamped count log in RAM and order request queues.
//
//  port group  | dir | handshake          | word
//  ------------+-----+--------------------+-------------------------
//  s_*         | in  | s_valid / s_ready  | in_word_t request
//  m_*         | out | m_valid / m_ready  | out_word_t result
//  cfg_*       | in  | cfg_we             | index 0 limit, 1 length
//
// One request at a time. A request is dispatched on its kind; kinds that admit read
// and check each expired log entry, and the first entry that stays, before admission;
// in-place updates and stale ticks go straight to the result; pause and cancel all
// walk the queued submits. The next word is taken the cycle after the final word loads.
// Reset (aresetn low, synchronous) empties log and queues, no clearing pass.
// A result waiting on m_ready stalls only the step that needs the out slot.
module sliding_window_order_rate_limiter_top
    import swrl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECIDE  = 7'b0000010,
        S_EXP_RD  = 7'b0000100,
        S_EXP_CHK = 7'b0001000,
        S_ADD     = 7'b0010000,
        S_WALK    = 7'b0100000,
        S_RESULT  = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] limit_reg;
    logic [31:0] length_reg;

    // request being worked on
    in_word_t    in_reg;
    logic [15:0] add_n_reg;

    // log ring: RAM plus head, fill and a copy of the newest entry
    log_entry_t  log_mem [LOG_DEPTH];
    log_entry_t  log_rd_reg;
    logic [LOG_AW-1:0] head_reg;
    logic [LOG_FW-1:0] log_fill_reg;
    logic [LOG_AW-1:0] back_addr_reg;
    log_entry_t  back_reg;
    logic [15:0] wc_reg;

    // queues
    sub_entry_t  sub_q   [SUBMIT_DEPTH];
    mod_entry_t  mod_q   [MOD_DEPTH];
    logic [15:0] can_q   [CANCEL_DEPTH];
    logic [SUB_FW-1:0] sub_fill_reg;
    logic [MOD_FW-1:0] mod_fill_reg;
    logic [CAN_FW-1:0] can_fill_reg;
    logic [SUB_AW-1:0] walk_idx_reg;

    // final result fields
    logic [2:0]  res_status_reg;
    logic [2:0]  res_atype_reg;
    logic [15:0] res_id_reg;
    logic [31:0] res_price_reg;
    logic [31:0] res_qty_reg;

    logic      m_valid_reg;
    out_word_t m_data_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    logic [15:0] count_left;
    assign count_left = (limit_reg > wc_reg) ? 16'(limit_reg - wc_reg) : 16'd0;

    // oldest matching queued submit and modify
    logic              sub_hit, mod_hit;
    logic [SUB_AW-1:0] sub_idx;
    logic [MOD_AW-1:0] mod_idx;
    always_comb begin
        sub_hit = 1'b0;
        sub_idx = '0;
        for (int i = SUBMIT_DEPTH - 1; i >= 0; i--) begin
            if (SUB_FW'(i) < sub_fill_reg && sub_q[i].id == in_reg.order_id) begin
                sub_hit = 1'b1;
                sub_idx = SUB_AW'(i);
            end
        end
        mod_hit = 1'b0;
        mod_idx = '0;
        for (int i = MOD_DEPTH - 1; i >= 0; i--) begin
            if (MOD_FW'(i) < mod_fill_reg && mod_q[i].id == in_reg.order_id) begin
                mod_hit = 1'b1;
                mod_idx = MOD_AW'(i);
            end
        end
    end

    // expiry test on the head entry
    logic [62:0] age;
    logic        expired;
    logic [15:0] wc_after_exp;
    assign age     = in_reg.now - log_rd_reg.stamp;
    assign expired = (in_reg.now >= log_rd_reg.stamp) && (age >= {31'd0, length_reg});
    assign wc_after_exp = (wc_reg >= log_rd_reg.cnt) ? 16'(wc_reg - log_rd_reg.cnt) : 16'd0;

    logic [LOG_AW-1:0] head_inc;
    assign head_inc = (head_reg == LOG_AW'(LOG_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // admission test and free slot
    logic [16:0]       wc_sum;
    logic              fits, merge, add_ok;
    logic [LOG_AW:0]   slot_sum;
    logic [LOG_AW-1:0] slot;
    assign wc_sum   = {1'b0, wc_reg} + {1'b0, add_n_reg};
    assign fits     = (wc_sum <= {1'b0, limit_reg});
    assign merge    = (log_fill_reg != '0) && (back_reg.stamp == in_reg.now);
    assign add_ok   = fits && (merge || log_fill_reg < LOG_FW'(LOG_DEPTH));
    assign slot_sum = (LOG_AW + 1)'(head_reg) + (LOG_AW + 1)'(log_fill_reg);
    assign slot     = (slot_sum >= (LOG_AW + 1)'(LOG_DEPTH))
                      ? LOG_AW'(slot_sum - (LOG_AW + 1)'(LOG_DEPTH)) : LOG_AW'(slot_sum);

    // log RAM: one write port, one registered read at the head
    logic       log_we;
    logic [LOG_AW-1:0] log_waddr;
    log_entry_t log_wdata;
    always_comb begin
        log_we    = (state_reg == S_ADD) && add_ok;
        log_waddr = merge ? back_addr_reg : slot;
        log_wdata = merge
                    ? log_entry_t'{stamp: back_reg.stamp, cnt: 16'(back_reg.cnt + add_n_reg)}
                    : log_entry_t'{stamp: in_reg.now, cnt: add_n_reg};
    end

    always_ff @(posedge aclk) begin
        if (log_we) begin
            log_mem[log_waddr] <= log_wdata;
        end
        log_rd_reg <= log_mem[head_reg];
    end

    // walk mode: set when the request being walked is a pause
    logic walk_pause;
    assign walk_pause = (in_reg.kind == KIND_PAUSE);

    // result word register load
    logic out_load;
    always_comb begin
        case (state_reg)
            S_WALK:   out_load = out_free && (!walk_pause ||
                                 sub_q[walk_idx_reg].cls != CLASS_OTHER);
            S_RESULT: out_load = out_free;
            default:  out_load = 1'b0;
        endcase
    end

    // result valid: set on a load, cleared once the word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            limit_reg    <= '0;
            length_reg   <= WINDOW_LENGTH_RESET;
            head_reg     <= '0;
            log_fill_reg <= '0;
            wc_reg       <= '0;
            sub_fill_reg <= '0;
            mod_fill_reg <= '0;
            can_fill_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WINDOW_LIMIT:  limit_reg  <= cfg_data[15:0];
                    CFG_WINDOW_LENGTH: length_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_DECIDE;
                    end
                end

                // dispatch on request kind
                S_DECIDE: begin
                    res_status_reg <= ST_REJECTED;
                    res_atype_reg  <= ACT_NONE;
                    res_id_reg     <= '0;
                    res_price_reg  <= '0;
                    res_qty_reg    <= '0;
                    add_n_reg      <= (in_reg.kind == KIND_RAW_ADD) ? in_reg.add_count : 16'd1;
                    case (in_reg.kind)
                        KIND_MOD_PRICE, KIND_MOD_QTY: begin
                            if (sub_hit) begin
                                if (in_reg.kind == KIND_MOD_PRICE)
                                    sub_q[sub_idx].price <= in_reg.new_price;
                                else
                                    sub_q[sub_idx].qty <= in_reg.new_quantity;
                                res_status_reg <= ST_UPDATED;
                                state_reg      <= S_RESULT;
                            end else if (mod_hit) begin
                                if (in_reg.kind == KIND_MOD_PRICE)
                                    mod_q[mod_idx].price <= in_reg.new_price;
                                else
                                    mod_q[mod_idx].qty <= in_reg.new_quantity;
                                res_status_reg <= ST_UPDATED;
                                state_reg      <= S_RESULT;
                            end else begin
                                state_reg <= S_EXP_RD;
                            end
                        end
                        KIND_CANCEL: begin
                            if (sub_hit) begin
                                for (int i = 0; i < SUBMIT_DEPTH - 1; i++)
                                    if (SUB_AW'(i) >= sub_idx) sub_q[i] <= sub_q[i + 1];
                                sub_fill_reg   <= sub_fill_reg - 1'b1;
                                res_status_reg <= ST_UPDATED;
                                state_reg      <= S_RESULT;
                            end else begin
                                if (mod_hit) begin
                                    for (int i = 0; i < MOD_DEPTH - 1; i++)
                                        if (MOD_AW'(i) >= mod_idx) mod_q[i] <= mod_q[i + 1];
                                    mod_fill_reg <= mod_fill_reg - 1'b1;
                                end
                                state_reg <= S_EXP_RD;
                            end
                        end
                        KIND_TICK: begin
                            res_status_reg <= ST_NO_ACTION;
                            if (wc_reg < limit_reg && (can_fill_reg != '0 ||
                                mod_fill_reg != '0 || sub_fill_reg != '0))
                                state_reg <= S_EXP_RD;
                            else
                                state_reg <= S_RESULT;
                        end
                        KIND_PAUSE, KIND_CANCEL_ALL: begin
                            walk_idx_reg <= walk_pause ? SUB_AW'(sub_fill_reg - 1'b1) : '0;
                            if (sub_fill_reg == '0) begin
                                mod_fill_reg   <= '0;
                                can_fill_reg   <= '0;
                                res_status_reg <= ST_DONE;
                                state_reg      <= S_RESULT;
                            end else begin
                                state_reg <= S_WALK;
                            end
                        end
                        default: state_reg <= S_EXP_RD;
                    endcase
                end

                // expiry: head is read this cycle, checked the next
                S_EXP_RD: begin
                    state_reg <= (log_fill_reg == '0) ? S_ADD : S_EXP_CHK;
                end

                S_EXP_CHK: begin
                    if (expired) begin
                        wc_reg       <= wc_after_exp;
                        head_reg     <= head_inc;
                        log_fill_reg <= log_fill_reg - 1'b1;
                        state_reg    <= S_EXP_RD;
                    end else begin
                        state_reg <= S_ADD;
                    end
                end

                // admission, then queueing or draining
                S_ADD: begin
                    state_reg <= S_RESULT;
                    if (add_ok) begin
                        wc_reg <= wc_sum[15:0];
                        if (merge) begin
                            back_reg.cnt <= log_wdata.cnt;
                        end else begin
                            back_reg      <= log_wdata;
                            back_addr_reg <= slot;
                            log_fill_reg  <= log_fill_reg + 1'b1;
                        end
                    end
                    case (in_reg.kind)
                        KIND_SUBMIT: begin
                            if (add_ok) begin
                                res_status_reg <= ST_ALLOWED;
                            end else if (sub_fill_reg < SUB_FW'(SUBMIT_DEPTH) &&
                                         limit_reg != '0) begin
                                sub_q[SUB_AW'(sub_fill_reg)] <= '{id: in_reg.order_id,
                                    price: in_reg.new_price, qty: in_reg.new_quantity,
                                    cls: in_reg.order_class};
                                sub_fill_reg   <= sub_fill_reg + 1'b1;
                                res_status_reg <= ST_QUEUED;
                            end
                        end
                        KIND_MOD_PRICE, KIND_MOD_QTY: begin
                            if (add_ok) begin
                                res_status_reg <= ST_ALLOWED;
                            end else if (mod_fill_reg < MOD_FW'(MOD_DEPTH)) begin
                                mod_q[MOD_AW'(mod_fill_reg)] <= '{id: in_reg.order_id,
                                    price: (in_reg.kind == KIND_MOD_PRICE) ? in_reg.new_price : '0,
                                    qty: (in_reg.kind == KIND_MOD_QTY) ? in_reg.new_quantity : '0,
                                    is_qty: (in_reg.kind == KIND_MOD_QTY)};
                                mod_fill_reg   <= mod_fill_reg + 1'b1;
                                res_status_reg <= ST_QUEUED;
                            end
                        end
                        KIND_CANCEL: begin
                            if (add_ok) begin
                                res_status_reg <= ST_ALLOWED;
                            end else if (can_fill_reg < CAN_FW'(CANCEL_DEPTH)) begin
                                can_q[CAN_AW'(can_fill_reg)] <= in_reg.order_id;
                                can_fill_reg   <= can_fill_reg + 1'b1;
                                res_status_reg <= ST_QUEUED;
                            end
                        end
                        KIND_TICK: begin
                            if (add_ok) begin
                                res_status_reg <= ST_ACTION;
                                if (can_fill_reg != '0) begin
                                    res_atype_reg <= ACT_CANCEL;
                                    res_id_reg    <= can_q[0];
                                    for (int i = 0; i < CANCEL_DEPTH - 1; i++)
                                        can_q[i] <= can_q[i + 1];
                                    can_fill_reg <= can_fill_reg - 1'b1;
                                end else if (mod_fill_reg != '0) begin
                                    res_id_reg <= mod_q[0].id;
                                    if (mod_q[0].is_qty) begin
                                        res_atype_reg <= ACT_MOD_QTY;
                                        res_qty_reg   <= mod_q[0].qty;
                                    end else begin
                                        res_atype_reg <= ACT_MOD_PRICE;
                                        res_price_reg <= mod_q[0].price;
                                    end
                                    for (int i = 0; i < MOD_DEPTH - 1; i++)
                                        mod_q[i] <= mod_q[i + 1];
                                    mod_fill_reg <= mod_fill_reg - 1'b1;
                                end else begin
                                    res_atype_reg <= ACT_SUBMIT;
                                    res_id_reg    <= sub_q[0].id;
                                    res_price_reg <= sub_q[0].price;
                                    res_qty_reg   <= sub_q[0].qty;
                                    for (int i = 0; i < SUBMIT_DEPTH - 1; i++)
                                        sub_q[i] <= sub_q[i + 1];
                                    sub_fill_reg <= sub_fill_reg - 1'b1;
                                end
                            end
                        end
                        default: res_status_reg <= add_ok ? ST_ALLOWED : ST_REJECTED;
                    endcase
                end

                // pause walks newest to oldest, cancel all oldest to newest
                S_WALK: begin
                    if (walk_pause) begin
                        if (sub_q[walk_idx_reg].cls == CLASS_OTHER || out_free) begin
                            if (sub_q[walk_idx_reg].cls != CLASS_OTHER) begin
                                m_data_reg  <= '{status: ST_CANCELED, action_type: ACT_NONE,
                                    out_order_id: sub_q[walk_idx_reg].id, out_price: '0,
                                    out_quantity: '0, count_in_window: wc_reg,
                                    count_left: count_left, last_result: 1'b0};
                                for (int i = 0; i < SUBMIT_DEPTH - 1; i++)
                                    if (SUB_AW'(i) >= walk_idx_reg) sub_q[i] <= sub_q[i + 1];
                                sub_fill_reg <= sub_fill_reg - 1'b1;
                            end
                            if (walk_idx_reg == '0) begin
                                mod_fill_reg   <= '0;
                                can_fill_reg   <= '0;
                                res_status_reg <= ST_DONE;
                                state_reg      <= S_RESULT;
                            end else begin
                                walk_idx_reg <= walk_idx_reg - 1'b1;
                            end
                        end
                    end else if (out_free) begin
                        m_data_reg  <= '{status: ST_CANCELED, action_type: ACT_NONE,
                            out_order_id: sub_q[walk_idx_reg].id, out_price: '0,
                            out_quantity: '0, count_in_window: wc_reg,
                            count_left: count_left, last_result: 1'b0};
                        if (SUB_FW'(walk_idx_reg) == sub_fill_reg - 1'b1) begin
                            sub_fill_reg   <= '0;
                            mod_fill_reg   <= '0;
                            can_fill_reg   <= '0;
                            res_status_reg <= ST_DONE;
                            state_reg      <= S_RESULT;
                        end else begin
                            walk_idx_reg <= walk_idx_reg + 1'b1;
                        end
                    end
                end

                // final word of the request
                S_RESULT: begin
                    if (out_free) begin
                        m_data_reg  <= '{status: res_status_reg, action_type: res_atype_reg,
                            out_order_id: res_id_reg, out_price: res_price_reg,
                            out_quantity: res_qty_reg, count_in_window: wc_reg,
                            count_left: count_left, last_result: 1'b1};
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_log_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        log_fill_reg <= LOG_FW'(LOG_DEPTH))
        else $error("log fill beyond depth");

    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_fill_reg <= SUB_FW'(SUBMIT_DEPTH) && mod_fill_reg <= MOD_FW'(MOD_DEPTH) &&
        can_fill_reg <= CAN_FW'(CANCEL_DEPTH))
        else $error("queue fill beyond depth");

    a_head_read_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EXP_CHK |-> log_fill_reg != '0)
        else $error("expiry check on an empty log");

    a_walk_has_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> sub_fill_reg != '0)
        else $error("queue walk with no queued submit");

endmodule
